// ===== src/qte_pkg.sv =====
`default_nettype none

package qte_pkg;

   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH_DEF     = 16;
   localparam int CORDIC_STAGES_DEF   = 16;

   // cordic angle accumulator, q30 radians
   localparam int     ZW          = 34;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // pitch path: sine in q30, cosine from the square root unit
   localparam int PITCH_IN_WIDTH = 32;
   localparam int SQRT_BITS      = 31;
   localparam int RAD_WIDTH      = 61;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [29:0] ATAN_Q30 [32] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
      30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
      30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
      30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
      30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
      30'h00000001, 30'h00000000
   };

   // components wider than 24 bits lose their low bits first
   function automatic int ext_width(input int cw);
      return (cw > 24) ? 24 : cw;
   endfunction

   function automatic int prod_width(input int cw);
      return 2 * ext_width(cw) + 2;
   endfunction

   // saturation bound of an output angle at the output scale
   function automatic longint angle_limit(input longint lim_q30, input int aw);
      int sh;
      sh = 33 - aw;
      return (lim_q30 + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

endpackage

`default_nettype wire

// ===== src/qte_queue.sv =====
`default_nettype none

module qte_queue
   import qte_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head_data,
   output logic                  empty,
   output logic                  full
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == (PW+1)'(DEPTH));
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/qte_front.sv =====
`default_nettype none

module qte_front
   import qte_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  wire logic signed [COMPONENT_WIDTH-1:0] quat_w,
   input  wire logic signed [COMPONENT_WIDTH-1:0] quat_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] quat_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] quat_z,
   output logic out_valid,
   output logic [4*prod_width(COMPONENT_WIDTH)+PITCH_IN_WIDTH-1:0] out_pl,
   output logic [SQRT_BITS-1:0] out_cos
);

   localparam int EW    = ext_width(COMPONENT_WIDTH);
   localparam int DROP  = COMPONENT_WIDTH - EW;
   localparam int MW    = 2 * EW;
   localparam int PW    = prod_width(COMPONENT_WIDTH);
   localparam int FRAC2 = 2 * (EW - 2);
   localparam int PLW   = 4 * PW + PITCH_IN_WIDTH;
   localparam int SHL   = (FRAC2 < 30) ? 30 - FRAC2 : 0;
   localparam int SHR   = (FRAC2 > 30) ? FRAC2 - 30 : 0;
   localparam longint SIN_ONE = longint'(1) <<< FRAC2;
   localparam longint SIN_HI  = (longint'(99999) <<< FRAC2) / 100000;
   localparam logic signed [PW-1:0] S_HI = PW'(SIN_HI);
   localparam logic signed [PW-1:0] S_LO = PW'(-SIN_ONE);

   // input stage with low bits dropped
   logic signed [COMPONENT_WIDTH-1:0] w_sh, x_sh, y_sh, z_sh;
   logic signed [EW-1:0] w0_ff, x0_ff, y0_ff, z0_ff;
   logic                 v0_ff;

   assign w_sh = quat_w >>> DROP;
   assign x_sh = quat_x >>> DROP;
   assign y_sh = quat_y >>> DROP;
   assign z_sh = quat_z >>> DROP;

   // products
   logic signed [MW-1:0] xy_ff, wz_ff, ww_ff, xx_ff, yy_ff, zz_ff, yz_ff, wx_ff, wy_ff, xz_ff;
   logic                 v1_ff;

   // sums
   logic signed [PW-1:0] ny_ff, dy_ff, nr_ff, dr_ff, s2_ff;
   logic                 v2_ff;

   // clamped sine in q30
   logic signed [PW-1:0] s_clamp;
   logic signed [63:0]   s64;
   logic [PLW-1:0]       pl3_ff;
   logic signed [PITCH_IN_WIDTH-1:0] s3_ff;
   logic                 v3_ff;

   // square of the sine
   logic [PLW-1:0]       pl4_ff;
   logic [RAD_WIDTH-1:0] sq4_ff;
   logic signed [63:0]   sq_full;
   logic                 v4_ff;

   // square root digit stages
   logic [RAD_WIDTH-1:0] rem_ff  [SQRT_BITS+1];
   logic [SQRT_BITS-1:0] root_ff [SQRT_BITS+1];
   logic [PLW-1:0]       pl_ff   [SQRT_BITS+1];
   logic                 sv_ff   [SQRT_BITS+1];

   always_comb begin
      if (s2_ff > S_HI) begin
         s_clamp = S_HI;
      end else if (s2_ff < S_LO) begin
         s_clamp = S_LO;
      end else begin
         s_clamp = s2_ff;
      end
      s64     = (64'(s_clamp) <<< SHL) >>> SHR;
      sq_full = 64'(s3_ff) * 64'(s3_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w0_ff <= w_sh[EW-1:0];
         x0_ff <= x_sh[EW-1:0];
         y0_ff <= y_sh[EW-1:0];
         z0_ff <= z_sh[EW-1:0];
         xy_ff <= MW'(x0_ff) * MW'(y0_ff);
         wz_ff <= MW'(w0_ff) * MW'(z0_ff);
         ww_ff <= MW'(w0_ff) * MW'(w0_ff);
         xx_ff <= MW'(x0_ff) * MW'(x0_ff);
         yy_ff <= MW'(y0_ff) * MW'(y0_ff);
         zz_ff <= MW'(z0_ff) * MW'(z0_ff);
         yz_ff <= MW'(y0_ff) * MW'(z0_ff);
         wx_ff <= MW'(w0_ff) * MW'(x0_ff);
         wy_ff <= MW'(w0_ff) * MW'(y0_ff);
         xz_ff <= MW'(x0_ff) * MW'(z0_ff);
         ny_ff <= (PW'(xy_ff) + PW'(wz_ff)) <<< 1;
         dy_ff <= PW'(ww_ff) + PW'(xx_ff) - PW'(yy_ff) - PW'(zz_ff);
         nr_ff <= (PW'(yz_ff) + PW'(wx_ff)) <<< 1;
         dr_ff <= PW'(ww_ff) - PW'(xx_ff) - PW'(yy_ff) + PW'(zz_ff);
         s2_ff <= (PW'(wy_ff) - PW'(xz_ff)) <<< 1;
         s3_ff  <= s64[PITCH_IN_WIDTH-1:0];
         pl3_ff <= {ny_ff, dy_ff, nr_ff, dr_ff, s64[PITCH_IN_WIDTH-1:0]};
         sq4_ff <= sq_full[RAD_WIDTH-1:0];
         pl4_ff <= pl3_ff;
         rem_ff[0]  <= (RAD_WIDTH'(1) << 60) - sq4_ff;
         root_ff[0] <= '0;
         pl_ff[0]   <= pl4_ff;
      end
   end

   for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
      localparam int B = SQRT_BITS - 1 - k;
      logic [RAD_WIDTH:0] trial;
      logic               take;

      assign trial = ((RAD_WIDTH+1)'(root_ff[k]) << (B + 1)) | ((RAD_WIDTH+1)'(1) << (2 * B));
      assign take  = ((RAD_WIDTH+1)'(rem_ff[k]) >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take ? rem_ff[k] - trial[RAD_WIDTH-1:0] : rem_ff[k];
            root_ff[k+1] <= take ? root_ff[k] | (SQRT_BITS'(1) << B) : root_ff[k];
            pl_ff[k+1]   <= pl_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int k = 0; k <= SQRT_BITS; k++) begin
            sv_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v0_ff    <= in_valid;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         sv_ff[0] <= v4_ff;
         for (int k = 0; k < SQRT_BITS; k++) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end
   end

   assign out_valid = sv_ff[SQRT_BITS];
   assign out_pl    = pl_ff[SQRT_BITS];
   assign out_cos   = root_ff[SQRT_BITS];

endmodule

`default_nettype wire

// ===== src/qte_cordic.sv =====
`default_nettype none

module qte_cordic
   import qte_pkg::*;
#(
   parameter int IN_WIDTH      = 32,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic clock,
   input  wire logic en,
   input  wire logic signed [IN_WIDTH-1:0] y_in,
   input  wire logic signed [IN_WIDTH-1:0] x_in,
   output logic signed [ZW-1:0] z_out
);

   localparam int DW = IN_WIDTH + 2;
   localparam int NS = CORDIC_STAGES;

   logic signed [DW-1:0] x_ff [NS+1];
   logic signed [DW-1:0] y_ff [NS+1];
   logic signed [ZW-1:0] z_ff [NS+1];
   logic                 zero_ff [NS+1];

   logic signed [DW-1:0] xe, ye;

   assign xe = DW'(x_in);
   assign ye = DW'(y_in);

   // left half plane is turned by pi first
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (xe < 0) begin
            x_ff[0] <= -xe;
            y_ff[0] <= -ye;
            z_ff[0] <= (ye >= 0) ? ZW'(PI_Q30) : ZW'(-PI_Q30);
         end else begin
            x_ff[0] <= xe;
            y_ff[0] <= ye;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic signed [DW-1:0] xs, ys;
      logic signed [ZW-1:0] at;

      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign at = signed'(ZW'(ATAN_Q30[i]));

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + at;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - at;
            end
         end
      end
   end

   assign z_out = zero_ff[NS] ? '0 : z_ff[NS];

endmodule

`default_nettype wire

// ===== src/qte_back.sv =====
`default_nettype none

module qte_back
   import qte_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  wire logic [4*prod_width(COMPONENT_WIDTH)+PITCH_IN_WIDTH-1:0] in_pl,
   input  wire logic [SQRT_BITS-1:0] in_cos,
   output logic out_valid,
   output logic signed [ANGLE_WIDTH-1:0] roll_angle,
   output logic signed [ANGLE_WIDTH-2:0] pitch_angle,
   output logic signed [ANGLE_WIDTH-1:0] yaw_angle
);

   localparam int PW = prod_width(COMPONENT_WIDTH);
   localparam int NS = CORDIC_STAGES;
   localparam int SH = 33 - ANGLE_WIDTH;
   localparam logic signed [ZW:0] LIM_PI = (ZW+1)'(angle_limit(PI_Q30, ANGLE_WIDTH));
   localparam logic signed [ZW:0] LIM_HP = (ZW+1)'(angle_limit(HALF_PI_Q30, ANGLE_WIDTH));

   logic signed [PW-1:0] ny, dy, nr, dr;
   logic signed [PITCH_IN_WIDTH-1:0] sn, cs;
   logic signed [ZW-1:0] z_yaw, z_roll, z_pitch;
   logic signed [ZW:0]   r_yaw, r_roll, r_pitch;
   logic                 v_ff [NS+2];

   assign {ny, dy, nr, dr, sn} = in_pl;
   assign cs = PITCH_IN_WIDTH'(in_cos);

   function automatic logic signed [ZW:0] round_sat(input logic signed [ZW-1:0] z,
                                                    input logic signed [ZW:0] lim);
      logic signed [ZW:0] v;
      v = ((ZW+1)'(z) + ((ZW+1)'(1) <<< (SH - 1))) >>> SH;
      if (v > lim) begin
         v = lim;
      end else if (v < -lim) begin
         v = -lim;
      end
      return v;
   endfunction

   qte_cordic #(.IN_WIDTH(PW), .CORDIC_STAGES(NS)) u_yaw (
      .clock (clock), .en (en), .y_in (ny), .x_in (dy), .z_out (z_yaw)
   );

   qte_cordic #(.IN_WIDTH(PW), .CORDIC_STAGES(NS)) u_roll (
      .clock (clock), .en (en), .y_in (nr), .x_in (dr), .z_out (z_roll)
   );

   qte_cordic #(.IN_WIDTH(PITCH_IN_WIDTH), .CORDIC_STAGES(NS)) u_pitch (
      .clock (clock), .en (en), .y_in (sn), .x_in (cs), .z_out (z_pitch)
   );

   assign r_yaw   = round_sat(z_yaw, LIM_PI);
   assign r_roll  = round_sat(z_roll, LIM_PI);
   assign r_pitch = round_sat(z_pitch, LIM_HP);

   always_ff @(posedge clock) begin
      if (en) begin
         roll_angle  <= r_roll[ANGLE_WIDTH-1:0];
         pitch_angle <= r_pitch[ANGLE_WIDTH-2:0];
         yaw_angle   <= r_yaw[ANGLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS + 2; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 0; k < NS + 1; k++) begin
            v_ff[k+1] <= v_ff[k];
         end
      end
   end

   assign out_valid = v_ff[NS+1];

endmodule

`default_nettype wire

// ===== src/quaternion_to_euler_angles.sv =====
// quaternion to z-y-x euler angles. each transfer on the req_ side carries one
// orientation quaternion (w, x, y, z, signed q1.14 at the default width); each
// transfer on the rsp_ side returns roll, pitch and yaw in radians, signed
// q3.13 at the default width (pitch q2.13), in the order the quaternions
// came in. roll and yaw are four-quadrant arctangents, pitch is the arcsine
// of 2(wy - xz) with the sine held to [-1, 0.99999]; roll and yaw saturate
// at +-pi, pitch at +-pi/2. a zero quaternion gives all three angles zero.
// the block takes one quaternion per cycle for as long as results are
// drained; the rate is set by the fully pipelined product, square root and
// cordic datapaths. an item passes through the front end (products, sums,
// sine clamp, sine square and a 31-stage square root), the 4-entry queue
// between front and back, the back end and the 4-entry result queue.
`default_nettype none

module quaternion_to_euler_angles
   import qte_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   output logic      full,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   output logic      empty,
   input  wire logic pop,
   output logic signed [ANGLE_WIDTH-1:0] rsp_roll_angle,
   output logic signed [ANGLE_WIDTH-2:0] rsp_pitch_angle,
   output logic signed [ANGLE_WIDTH-1:0] rsp_yaw_angle
);

   localparam int PW  = prod_width(COMPONENT_WIDTH);
   localparam int PLW = 4 * PW + PITCH_IN_WIDTH;
   localparam int MQW = PLW + SQRT_BITS;
   localparam int OQW = 3 * ANGLE_WIDTH - 1;
   localparam logic signed [ANGLE_WIDTH-1:0] LIM_PI =
      ANGLE_WIDTH'(angle_limit(PI_Q30, ANGLE_WIDTH));
   localparam logic signed [ANGLE_WIDTH-2:0] LIM_HP =
      (ANGLE_WIDTH-1)'(angle_limit(HALF_PI_Q30, ANGLE_WIDTH));

   // front side: advances whenever the middle queue has room
   logic           en_front;
   logic           front_valid;
   logic [PLW-1:0] front_pl;
   logic [SQRT_BITS-1:0] front_cos;

   // middle queue
   logic           mid_push, mid_pop, mid_empty, mid_full;
   logic [MQW-1:0] mid_head;

   // back side: advances whenever the result queue has room
   logic           en_back;
   logic           back_valid;
   logic signed [ANGLE_WIDTH-1:0] back_roll, back_yaw;
   logic signed [ANGLE_WIDTH-2:0] back_pitch;

   // result queue
   logic           out_push, out_pop, out_full;
   logic [OQW-1:0] out_head;

   assign en_front = !mid_full;
   assign full     = mid_full;
   assign mid_push = en_front && front_valid;
   assign en_back  = !out_full;
   assign mid_pop  = en_back && !mid_empty;
   assign out_push = en_back && back_valid;
   assign out_pop  = pop && !empty;

   qte_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en_front),
      .in_valid  (push),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .out_valid (front_valid),
      .out_pl    (front_pl),
      .out_cos   (front_cos)
   );

   qte_queue #(.WIDTH(MQW), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data ({front_pl, front_cos}),
      .pop       (mid_pop),
      .head_data (mid_head),
      .empty     (mid_empty),
      .full      (mid_full)
   );

   qte_back #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .ANGLE_WIDTH     (ANGLE_WIDTH),
      .CORDIC_STAGES   (CORDIC_STAGES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (en_back),
      .in_valid    (!mid_empty),
      .in_pl       (mid_head[MQW-1:SQRT_BITS]),
      .in_cos      (mid_head[SQRT_BITS-1:0]),
      .out_valid   (back_valid),
      .roll_angle  (back_roll),
      .pitch_angle (back_pitch),
      .yaw_angle   (back_yaw)
   );

   qte_queue #(.WIDTH(OQW), .DEPTH(QUEUE_DEPTH)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data ({back_roll, back_pitch, back_yaw}),
      .pop       (out_pop),
      .head_data (out_head),
      .empty     (empty),
      .full      (out_full)
   );

   assign {rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle} = out_head;

   // a stalled side holds its last stage
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      !en_front |=> $stable(front_valid))
      else $error("front output changed while stalled");

   a_back_hold: assert property (@(posedge clock) disable iff (reset)
      !en_back |=> $stable(back_valid))
      else $error("back output changed while stalled");

   // results stay inside their saturation bounds
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_pitch_angle <= LIM_HP) && (rsp_pitch_angle >= -LIM_HP))
      else $error("pitch out of range");

   a_roll_yaw_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_roll_angle <= LIM_PI) && (rsp_roll_angle >= -LIM_PI)
                 && (rsp_yaw_angle <= LIM_PI) && (rsp_yaw_angle >= -LIM_PI))
      else $error("roll or yaw out of range");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb;
   import qte_pkg::*;

   localparam int CW        = COMPONENT_WIDTH_DEF;
   localparam int AW        = ANGLE_WIDTH_DEF;
   localparam int STAGES    = CORDIC_STAGES_DEF;
   localparam int LATENCY   = 60;
   localparam int MAX_CYCLES = 400000;
   localparam int RAND_ITEMS = 1430;
   localparam int HOLD_ITEMS = 100;

   typedef struct packed {
      logic signed [AW-1:0] roll;
      logic signed [AW-2:0] pitch;
      logic signed [AW-1:0] yaw;
   } euler_t;

   typedef struct {
      logic signed [CW-1:0] w, x, y, z;
      bit                   typed;
      euler_t               angles;
   } quat_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push  = 1'b0;
   logic pop   = 1'b0;
   logic full, empty;
   logic signed [CW-1:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic signed [AW-1:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [AW-2:0] rsp_pitch_angle;

   quaternion_to_euler_angles u_top (
      .clock, .reset, .push, .full,
      .req_quat_w, .req_quat_x, .req_quat_y, .req_quat_z,
      .empty, .pop, .rsp_roll_angle, .rsp_pitch_angle, .rsp_yaw_angle
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected angles in transfer order, plus overrides from the typed rows
   euler_t pending_angles[$];
   euler_t next_typed;
   bit     next_is_typed = 1'b0;
   bit     failed = 1'b0;
   int     cycle_count = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   int     hold_requests = 0;
   int     holds_served = 0;
   int     hold_left = 0;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // four-quadrant arctangent, q30 radians
   function automatic longint atan2_q30(input longint y, input longint x);
      longint ang, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      // left half plane: turn by pi first
      if (x < 0) begin
         ang = (y >= 0) ? PI_Q30 : -PI_Q30;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x   = x + ys;
            y   = y - xs;
            ang = ang + longint'(ATAN_Q30[i]);
         end else begin
            x   = x - ys;
            y   = y + xs;
            ang = ang - longint'(ATAN_Q30[i]);
         end
      end
      return ang;
   endfunction

   // round q30 to the output scale, then saturate
   function automatic longint scale_angle(input longint ang, input longint lim_q30);
      longint half, lim, v;
      half = longint'(1) <<< (32 - AW);
      lim  = (lim_q30 + half) >>> (33 - AW);
      v    = (ang + half) >>> (33 - AW);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic euler_t predict_euler(input logic signed [CW-1:0] qw, qx, qy, qz);
      longint w, x, y, z, sine, sine30, one, hi;
      longint unsigned cosine;
      euler_t r;
      w = qw; x = qx; y = qy; z = qz;
      one = longint'(1) <<< (2 * (CW - 2));
      hi  = (99999 * one) / 100000;
      r.yaw  = AW'(scale_angle(atan2_q30(2 * (x * y + w * z), w*w + x*x - y*y - z*z), PI_Q30));
      r.roll = AW'(scale_angle(atan2_q30(2 * (y * z + w * x), w*w - x*x - y*y + z*z), PI_Q30));
      // sine of pitch, held to [-1, 0.99999], then moved to q30
      sine = 2 * (w * y - x * z);
      if (sine > hi) sine = hi;
      if (sine < -one) sine = -one;
      sine30 = sine <<< (30 - 2 * (CW - 2));
      cosine = int_sqrt((64'd1 << 60) - longint'(sine30 * sine30));
      r.pitch = (AW-1)'(scale_angle(atan2_q30(sine30, longint'(cosine)), HALF_PI_Q30));
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // monitor: record every req transfer, check every rsp transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      euler_t want;
      if (!reset && push && !full) begin
         if (next_is_typed) pending_angles.push_back(next_typed);
         else pending_angles.push_back(predict_euler(req_quat_w, req_quat_x,
                                                     req_quat_y, req_quat_z));
      end
      if (!reset && pop && !empty) begin
         if (pending_angles.size() == 0) begin
            $display("%0t: rsp transfer with nothing expected", $time);
            failed = 1'b1;
         end else begin
            want = pending_angles.pop_front();
            if (rsp_roll_angle !== want.roll) begin
               $display("%0t: roll expected %0d actual %0d", $time, want.roll, rsp_roll_angle);
               failed = 1'b1;
            end
            if (rsp_pitch_angle !== want.pitch) begin
               $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                        rsp_pitch_angle);
               failed = 1'b1;
            end
            if (rsp_yaw_angle !== want.yaw) begin
               $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, rsp_yaw_angle);
               failed = 1'b1;
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= 300;
         pop          <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("quaternion_to_euler_angles test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------
   task automatic send_quat(input logic signed [CW-1:0] w, x, y, z,
                            input bit typed, input euler_t angles);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push       <= 1'b1;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      next_is_typed <= typed;
      next_typed    <= angles;
      do @(posedge clock); while (full);
   endtask

   function automatic logic signed [CW-1:0] rand_comp(input int mode);
      case (mode)
         0: return CW'($urandom_range(32768) - 16384);
         1: return CW'($urandom_range(64) - 32);
         2: return '0;
         default: return ($urandom_range(1)) ? CW'(16384) : CW'(-16384);
      endcase
   endfunction

   task automatic drain_all();
      push <= 1'b0;
      @(posedge clock);
      while (pending_angles.size() != 0) @(posedge clock);
   endtask

   quat_row_t directed[$];

   initial begin
      int phase;
      logic signed [CW-1:0] cw, cx, cy, cz;
      euler_t none_typed;
      none_typed = '0;

      // zero quaternion gives all angles zero; the rest go through the predictor
      directed = '{
         '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1, '0},
         '{16'sd16384,  16'sd0,      16'sd0,      16'sd0,      1'b0, '0},
         '{-16'sd16384, 16'sd0,      16'sd0,      16'sd0,      1'b0, '0},
         '{16'sd0,      16'sd16384,  16'sd0,      16'sd0,      1'b0, '0},
         '{16'sd0,      16'sd0,      16'sd16384,  16'sd0,      1'b0, '0},
         '{16'sd0,      16'sd0,      16'sd0,      16'sd16384,  1'b0, '0},
         '{16'sd0,      -16'sd16384, 16'sd0,      16'sd0,      1'b0, '0},
         '{16'sd0,      16'sd0,      -16'sd16384, 16'sd0,      1'b0, '0},
         '{16'sd0,      16'sd0,      16'sd0,      -16'sd16384, 1'b0, '0},
         // sine clamped high / low, then just inside the clamp
         '{16'sd16384,  16'sd0,      16'sd16384,  16'sd0,      1'b0, '0},
         '{16'sd16384,  16'sd0,      -16'sd16384, 16'sd0,      1'b0, '0},
         '{16'sd11585,  16'sd0,      16'sd11585,  16'sd0,      1'b0, '0},
         '{16'sd11585,  16'sd0,      -16'sd11585, 16'sd0,      1'b0, '0},
         // negative denominators, numerator both signs
         '{16'sd1000,   16'sd16000,  16'sd0,      16'sd100,    1'b0, '0},
         '{16'sd1000,   -16'sd16000, 16'sd0,      16'sd100,    1'b0, '0},
         '{16'sd100,    16'sd0,      16'sd16000,  16'sd200,    1'b0, '0},
         '{-16'sd100,   16'sd0,      16'sd16000,  16'sd200,    1'b0, '0},
         // non-unit: all extremes, then tiny and mixed
         '{16'sd16384,  16'sd16384,  16'sd16384,  16'sd16384,  1'b0, '0},
         '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 1'b0, '0},
         '{16'sd16384,  -16'sd16384, 16'sd16384,  -16'sd16384, 1'b0, '0},
         '{16'sd1,      16'sd0,      16'sd0,      16'sd0,      1'b0, '0},
         '{-16'sd1,     -16'sd1,     16'sd1,      -16'sd1,     1'b0, '0},
         '{16'sd5461,   -16'sd7,     16'sd9999,   -16'sd12000, 1'b0, '0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_quat(directed[i].w, directed[i].x, directed[i].y, directed[i].z,
                   directed[i].typed, directed[i].angles);

      // sender pauses until every result is back
      drain_all();

      // receiver holds off while the sender keeps offering, more than the block holds
      hold_requests = hold_requests + 1;
      for (int k = 0; k < HOLD_ITEMS; k++)
         send_quat(rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0), 1'b0, none_typed);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         for (int k = 0; k < RAND_ITEMS / 4; k++) begin
            // mostly full-range components, some small, zero or extreme
            cw = rand_comp($urandom_range(9) < 6 ? 0 : $urandom_range(3));
            cx = rand_comp($urandom_range(9) < 6 ? 0 : $urandom_range(3));
            cy = rand_comp($urandom_range(9) < 6 ? 0 : $urandom_range(3));
            cz = rand_comp($urandom_range(9) < 6 ? 0 : $urandom_range(3));
            send_quat(cw, cx, cy, cz, 1'b0, none_typed);
         end
      end

      drain_all();
      repeat (LATENCY) @(posedge clock);
      if (!failed && pending_angles.size() == 0) begin
         $display("quaternion_to_euler_angles test passed");
      end else begin
         $display("quaternion_to_euler_angles test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== quaternion_to_euler_angles.f =====
src/qte_pkg.sv
src/qte_queue.sv
src/qte_front.sv
src/qte_cordic.sv
src/qte_back.sv
src/quaternion_to_euler_angles.sv
dv/tb.sv
